// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the notification event filter. Each macro
// samples on the rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define NEF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define NEF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NEF_ASSERT_SAME(lbl, ante, cons)
`define NEF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- src/nef_pkg.sv -----
// ----------------------------------------------------------------------------
// nef_pkg
// Types, constants and codes shared by the notification event filter.
// ----------------------------------------------------------------------------
`default_nettype none

package nef_pkg;

  // Size of the recent identifier ring and of the category space.
  localparam int HISTORY_DEPTH  = 8;
  localparam int CATEGORY_COUNT = 12;

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  // Field widths.
  localparam int KIND_W   = 2;
  localparam int CAT_W    = 4;
  localparam int UID_W    = 32;
  localparam int TIME_W   = 32;
  localparam int MASK_W   = 12;
  localparam int GAP_W    = 16;
  localparam int VERD_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Port widths.
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CATEGORY_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONLY_CALLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CALLS_ALWAYS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP       = 2'd3;

  // Register reset values.
  localparam logic [MASK_W-1:0] MASK_RESET = 12'd62;
  localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd10000;

  // Event codes.
  localparam logic [KIND_W-1:0] KIND_REMOVED      = 2'd2;
  localparam logic [CAT_W-1:0]  CAT_INCOMING_CALL = 4'd1;

  // Verdict codes.
  typedef enum logic [VERD_W-1:0] {
    V_SHOW        = 3'd0,
    V_REMOVED     = 3'd1,
    V_PREEXISTING = 3'd2,
    V_ONLY_CALLS  = 3'd3,
    V_SILENT      = 3'd4,
    V_CATEGORY    = 3'd5,
    V_REPEAT      = 3'd6,
    V_TOO_SOON    = 3'd7
  } verdict_t;

  // Write request into the history ring.
  typedef struct packed {
    logic             en;
    logic [UID_W-1:0] uid;
  } hist_wr_t;

  // Flags from the shared compare unit.
  typedef struct packed {
    logic eq;
    logic lt_gap;
  } unit_res_t;

endpackage

`default_nettype wire

// ----- src/nef_unit.sv -----
// ----------------------------------------------------------------------------
// nef_unit
// Shared 32-bit subtractor: equality for the history scan and the wrapping
// time gap compare against the minimum gap.
// ----------------------------------------------------------------------------
`default_nettype none

module nef_unit
  import nef_pkg::*;
(
  input  wire logic [UID_W-1:0] op_a,
  input  wire logic [UID_W-1:0] op_b,
  input  wire logic [GAP_W-1:0] min_gap,
  output unit_res_t             res
);

  logic [UID_W-1:0] diff;

  // One subtraction serves both questions; the difference wraps modulo 2^32.
  assign diff       = op_a - op_b;
  assign res.eq     = (diff == '0);
  assign res.lt_gap = (diff < UID_W'(min_gap));

endmodule

`default_nettype wire

// ----- src/nef_hist.sv -----
// ----------------------------------------------------------------------------
// nef_hist
// Ring of recently shown identifiers with its write pointer and fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module nef_hist
  import nef_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hist_wr_t         wr,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic      [UID_W-1:0] rd_data,
  output logic      [CNT_W-1:0] count
);

  logic [UID_W-1:0] ids_r [HISTORY_DEPTH];
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Pointer wraps at the ring depth; the count saturates once the ring is full.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (wr.en) begin
      if (head_r == IDX_W'(HISTORY_DEPTH - 1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_r + IDX_W'(1);
      end
      if (count_r != CNT_W'(HISTORY_DEPTH)) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Entries are only read below the fill count, so they carry no reset.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      ids_r[head_r] <= wr.uid;
    end
  end

  assign rd_data = ids_r[rd_idx];
  assign count   = count_r;

endmodule

`default_nettype wire

// ----- src/notification_event_filter.sv -----
// ----------------------------------------------------------------------------
// notification_event_filter
// Takes one notification event per input beat and returns one verdict beat:
// show, or the reason for the drop. Rules are applied in a fixed order:
// removed, preexisting, always-shown incoming call, only-calls mode, silent,
// disabled category, repeat of a recently shown identifier, and too soon
// after the last shown event for non-important events. The block works on
// one event at a time: after accepting it, it applies the flag rules, then
// scans the valid history entries (up to eight) for a repeat, stopping at
// a match, then checks the gap, and then hands the verdict to the output
// register, waiting while the previous verdict still holds it. A deciding
// flag rule skips the scan and the gap check; an empty history skips the
// scan. The scan pace is set by the single shared 32-bit subtractor, which
// compares one history entry per cycle. The output register lets a new
// event enter while a verdict still waits downstream. Configuration writes
// are taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module notification_event_filter
  import nef_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input event channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // in_tdata: category [3:0], uid [35:4], now_ms [67:36], zero [71:68]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: event_kind [1:0], preexisting [2], silent_flag [3], important_flag [4]
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  // Verdict channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_tdata: verdict [2:0], zero [7:3]
  output logic      [OUT_DATA_W-1:0] out_tdata,
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_SCAN = 5'b00100,
    S_GAP  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [MASK_W-1:0] mask_r;
  logic              only_calls_r;
  logic              calls_always_r;
  logic [GAP_W-1:0]  min_gap_r;

  // Captured event
  logic [KIND_W-1:0] kind_r;
  logic              pre_r, silent_r, imp_r;
  logic [CAT_W-1:0]  cat_r;
  logic [UID_W-1:0]  uid_r;
  logic [TIME_W-1:0] now_r;

  // Sequencer and timing state
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  verdict_t          verd_r, verd_nxt;
  logic [TIME_W-1:0] last_ms_r;
  logic              shown_r;
  logic              out_valid_r, out_valid_nxt;
  verdict_t          out_verd_r;

  hist_wr_t          hist_wr;
  logic [UID_W-1:0]  hist_data;
  logic [CNT_W-1:0]  hist_count;
  logic [UID_W-1:0]  op_a, op_b;
  unit_res_t         ures;
  logic [MASK_W-1:0] mask_sh;
  logic              cat_en;
  logic              in_acc, out_load;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r         <= MASK_RESET;
      only_calls_r   <= 1'b0;
      calls_always_r <= 1'b1;
      min_gap_r      <= GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CATEGORY_MASK: mask_r         <= cfg_wdata[MASK_W-1:0];
        REG_ONLY_CALLS:    only_calls_r   <= cfg_wdata[0];
        REG_CALLS_ALWAYS:  calls_always_r <= cfg_wdata[0];
        REG_MIN_GAP:       min_gap_r      <= cfg_wdata[GAP_W-1:0];
        default:           mask_r         <= mask_r;
      endcase
    end
  end

  // Capture the event fields on the accepting beat.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r   <= in_tuser[1:0];
      pre_r    <= in_tuser[2];
      silent_r <= in_tuser[3];
      imp_r    <= in_tuser[4];
      cat_r    <= in_tdata[3:0];
      uid_r    <= in_tdata[35:4];
      now_r    <= in_tdata[67:36];
    end
  end

  // Categories at or above the category count are always disabled.
  assign mask_sh = mask_r >> cat_r;
  assign cat_en  = (32'(cat_r) < CATEGORY_COUNT) && mask_sh[0];

  // The shared unit compares against a history entry while scanning and
  // measures the time gap otherwise.
  assign op_a = (state_r == S_SCAN) ? uid_r : now_r;
  assign op_b = (state_r == S_SCAN) ? hist_data : last_ms_r;

  nef_unit u_unit (
    .op_a    (op_a),
    .op_b    (op_b),
    .min_gap (min_gap_r),
    .res     (ures)
  );

  nef_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (hist_wr),
    .rd_idx  (idx_r),
    .rd_data (hist_data),
    .count   (hist_count)
  );

  // Sequencer: flag rules, history scan, gap check, hand-off.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    verd_nxt    = verd_r;
    hist_wr.en  = 1'b0;
    hist_wr.uid = uid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        idx_nxt   = '0;
        state_nxt = S_DONE;
        priority if (kind_r == KIND_REMOVED) begin
          verd_nxt = V_REMOVED;
        end else if (pre_r) begin
          verd_nxt = V_PREEXISTING;
        end else if (cat_r == CAT_INCOMING_CALL && calls_always_r) begin
          verd_nxt   = V_SHOW;
          hist_wr.en = 1'b1;
        end else if (only_calls_r) begin
          verd_nxt = V_ONLY_CALLS;
        end else if (silent_r) begin
          verd_nxt = V_SILENT;
        end else if (!cat_en) begin
          verd_nxt = V_CATEGORY;
        end else if (hist_count == '0) begin
          state_nxt = S_GAP;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (ures.eq) begin
          verd_nxt  = V_REPEAT;
          state_nxt = S_DONE;
        end else if (CNT_W'(idx_r) + CNT_W'(1) == hist_count) begin
          state_nxt = S_GAP;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_GAP: begin
        state_nxt = S_DONE;
        if (!imp_r && shown_r && ures.lt_gap) begin
          verd_nxt = V_TOO_SOON;
        end else begin
          verd_nxt   = V_SHOW;
          hist_wr.en = 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      verd_r  <= V_SHOW;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      verd_r  <= verd_nxt;
    end
  end

  // A shown event stamps the time of the last show.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ms_r <= '0;
      shown_r   <= 1'b0;
    end else if (hist_wr.en) begin
      last_ms_r <= now_r;
      shown_r   <= 1'b1;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_verd_r <= verd_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_verd_r);

  // The block is busy for the cycle after it takes an event.
  `NEF_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready)
  // The scan never reads an entry at or beyond the fill count.
  `NEF_ASSERT_SAME(a_scan_in_range, state_r == S_SCAN, CNT_W'(idx_r) < hist_count)
  // A ring write always leaves a non-empty ring and a stamped show.
  `NEF_ASSERT_NEXT(a_write_fills, hist_wr.en, (hist_count != '0) && shown_r)

endmodule

`default_nettype wire
